// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the receive classifier RTL.
// No dependencies; every macro samples on clock and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ERX_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// A condition that must hold in the same cycle whenever the antecedent holds.
`define ERX_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/erx_pkg.sv =====
// Shared widths, codes and item types of the receive classifier and peer table.
// Used by every module of the block; depends on nothing.
package erx_pkg;

   localparam int ADDR_W     = 48;
   localparam int IFACE_W    = 4;
   localparam int TYPE_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int ACTION_W   = 2;
   localparam int SLOT_W     = 4;
   localparam int COUNT_W    = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int DEFAULT_TABLE_ENTRIES = 16;
   localparam int QUEUE_DEPTH           = 2;

   localparam logic [TYPE_W-1:0] MAX_LENGTH_VALUE = 16'd1500;
   localparam logic [TYPE_W-1:0] PROTO_RESET      = 16'h88AD;
   localparam logic [7:0]        BYTE_ALL_ONES    = 8'hFF;
   localparam int                GROUP_BIT        = 40;

   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_IFACE_DOWN = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OTHER      = 2'd2;

   localparam logic [ACTION_W-1:0] ACTION_MATCH   = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_NEW     = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_REPLACE = 2'd2;

   localparam logic CSR_IDX_PROTOCOL_TYPE = 1'b0;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                is_broadcast;
      logic                is_multicast;
      logic                llc_encap;
      logic [COUNT_W-1:0]  group_count;
      logic [IFACE_W-1:0]  iface_id;
      logic [ADDR_W-1:0]   source_addr;
   } job_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                is_broadcast;
      logic                is_multicast;
      logic                llc_encap;
      logic [SLOT_W-1:0]   slot;
      logic [ACTION_W-1:0] table_action;
      logic [COUNT_W-1:0]  group_count;
   } result_type;

endpackage

// ===== hw/rtl/erx_front.sv =====
// Front end: accepts frame headers, classifies them and keeps the group counter.
// Depends on erx_pkg; feeds erx_queue.
module erx_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_iface_up,
   input  logic [erx_pkg::IFACE_W-1:0]   req_iface_id,
   input  logic [erx_pkg::ADDR_W-1:0]    req_dst_mac,
   input  logic [erx_pkg::ADDR_W-1:0]    req_source_addr,
   input  logic [erx_pkg::TYPE_W-1:0]    req_frame_type,
   input  logic [erx_pkg::TYPE_W-1:0]    req_llc_type,
   input  logic [erx_pkg::TYPE_W-1:0]    protocol_type,
   input  logic                          queue_full,
   output logic                          push,
   output erx_pkg::job_type              push_job
);
   import erx_pkg::*;

   logic [COUNT_W-1:0] group_ff;
   logic [COUNT_W-1:0] group_in;
   logic               accept;
   logic               group_hit;
   logic               bcast;
   logic               llc;
   logic [TYPE_W-1:0]  eff_type;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;

   always_comb begin
      group_hit = req_iface_up && req_dst_mac[GROUP_BIT];
      bcast     = (req_dst_mac == {6{BYTE_ALL_ONES}});
      llc       = (req_frame_type <= MAX_LENGTH_VALUE);
      eff_type  = llc ? req_llc_type : req_frame_type;
      group_in  = group_ff + {{(COUNT_W-1){1'b0}}, group_hit};

      push_job.iface_id    = req_iface_id;
      push_job.source_addr = req_source_addr;
      push_job.group_count = group_in;
      if (!req_iface_up) begin
         push_job.status       = STATUS_IFACE_DOWN;
         push_job.is_broadcast = 1'b0;
         push_job.is_multicast = 1'b0;
         push_job.llc_encap    = 1'b0;
      end else begin
         push_job.status       = (eff_type == protocol_type) ? STATUS_ACCEPTED : STATUS_OTHER;
         push_job.is_broadcast = req_dst_mac[GROUP_BIT] && bcast;
         push_job.is_multicast = req_dst_mac[GROUP_BIT] && !bcast;
         push_job.llc_encap    = llc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= '0;
      end else if (accept) begin
         group_ff <= group_in;
      end
   end

endmodule

// ===== hw/rtl/erx_queue.sv =====
// Short queue of classified items between the front end and the table engine.
// Depends on erx_pkg for the item type.
module erx_queue #(
   parameter int DEPTH = erx_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  erx_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output erx_pkg::job_type pop_job,
   output logic             not_empty
);
   import erx_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hw/rtl/erx_back.sv =====
// Back end: scans the peer table one slot a cycle and drives the result register.
// Depends on erx_pkg and assert_macros.svh; takes items from erx_queue.
`include "assert_macros.svh"

module erx_back #(
   parameter int TABLE_ENTRIES = erx_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          not_empty,
   input  erx_pkg::job_type              pop_job,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output erx_pkg::result_type           rsp
);
   import erx_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int PTR_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   typedef struct packed {
      logic [IFACE_W-1:0] iface;
      logic [ADDR_W-1:0]  addr;
   } entry_type;

   entry_type                mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   entry_type                rd_entry_ff;
   logic                     rd_valid_ff;

   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   job_type           job_ff;
   job_type           job_in;
   logic [IDX_W-1:0]  iss_ff;
   logic [IDX_W-1:0]  iss_in;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic [IDX_W-1:0]  cmp_idx_in;
   logic              cmp_vld_ff;
   logic              cmp_vld_in;
   logic [PTR_W-1:0]  victim_ptr_ff;
   logic [PTR_W-1:0]  victim_ptr_in;
   result_type        res_ff;
   result_type        res_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   result_type        rsp_ff;
   result_type        rsp_in;

   logic              out_free;
   logic              load_out;
   logic [ADDR_W-1:0] cur_addr;
   logic              hit_match;
   logic              hit_empty;
   logic [IDX_W-1:0]  victim_idx;
   logic              mem_we;
   logic [IDX_W-1:0]  wr_idx;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      iss_in        = iss_ff;
      cmp_idx_in    = iss_ff;
      cmp_vld_in    = 1'b0;
      victim_ptr_in = victim_ptr_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      load_out      = 1'b0;
      pop           = 1'b0;
      mem_we        = 1'b0;
      wr_idx        = cmp_idx_ff;

      cur_addr   = rd_valid_ff ? rd_entry_ff.addr : '0;
      hit_match  = (cur_addr == job_ff.source_addr);
      hit_empty  = (cur_addr == '0);
      victim_idx = (victim_ptr_ff >= PTR_W'(TABLE_ENTRIES)) ? '0 : IDX_W'(victim_ptr_ff);

      unique case (state_ff)
         ST_IDLE: begin
            iss_in = '0;
            if (not_empty) begin
               if (pop_job.status == STATUS_ACCEPTED) begin
                  pop      = 1'b1;
                  job_in   = pop_job;
                  state_in = ST_SCAN;
               end else if (out_free) begin
                  pop                 = 1'b1;
                  load_out            = 1'b1;
                  rsp_in.status       = pop_job.status;
                  rsp_in.is_broadcast = pop_job.is_broadcast;
                  rsp_in.is_multicast = pop_job.is_multicast;
                  rsp_in.llc_encap    = pop_job.llc_encap;
                  rsp_in.slot         = '0;
                  rsp_in.table_action = ACTION_MATCH;
                  rsp_in.group_count  = pop_job.group_count;
               end
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b1;
            if (iss_ff != LAST_IDX) begin
               iss_in = iss_ff + IDX_W'(1);
            end
            if (cmp_vld_ff && (hit_match || hit_empty || cmp_idx_ff == LAST_IDX)) begin
               mem_we              = 1'b1;
               cmp_vld_in          = 1'b0;
               res_in.status       = job_ff.status;
               res_in.is_broadcast = job_ff.is_broadcast;
               res_in.is_multicast = job_ff.is_multicast;
               res_in.llc_encap    = job_ff.llc_encap;
               res_in.group_count  = job_ff.group_count;
               if (hit_match) begin
                  res_in.table_action = ACTION_MATCH;
               end else if (hit_empty) begin
                  res_in.table_action = ACTION_NEW;
               end else begin
                  wr_idx              = victim_idx;
                  victim_ptr_in       = PTR_W'(victim_idx) + PTR_W'(1);
                  res_in.table_action = ACTION_REPLACE;
               end
               res_in.slot = SLOT_W'(wr_idx);
               if (out_free) begin
                  load_out = 1'b1;
                  rsp_in   = res_in;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               load_out = 1'b1;
               rsp_in   = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cmp_vld_ff    <= 1'b0;
         victim_ptr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         cmp_vld_ff    <= cmp_vld_in;
         victim_ptr_ff <= victim_ptr_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (mem_we) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      iss_ff      <= iss_in;
      cmp_idx_ff  <= cmp_idx_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
      rd_valid_ff <= valid_ff[iss_ff];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx] <= '{iface: job_ff.iface_id, addr: job_ff.source_addr};
      end
      rd_entry_ff <= mem[iss_ff];
   end

   `ERX_ASSERT_IMPL(a_no_load_when_stalled, rsp_valid_ff && rsp_stall, !load_out, "result overwritten while stalled")
   `ERX_ASSERT_IMPL(a_write_on_decision, mem_we, state_ff == ST_SCAN && cmp_vld_ff, "table written outside a decision")
   `ERX_ASSERT(a_victim_range, victim_ptr_ff <= PTR_W'(TABLE_ENTRIES), "victim pointer out of range")
   `ERX_ASSERT_IMPL(a_pop_in_idle, pop, state_ff == ST_IDLE && not_empty, "queue popped while busy")

endmodule

// ===== hw/rtl/ether_rx_classify_peer_learn_unit.sv =====
// Top level of the receive classifier with peer-address learning table.
// Depends on erx_pkg, erx_front, erx_queue and erx_back.
//
// Usage:
//   The req_ channel takes one received frame header per item; the rsp_
//   channel returns exactly one result item per header, in order. Both use
//   valid and stall: an item moves at a clock edge with valid high and stall
//   low. The APB-style configuration port holds protocol_type at byte
//   address 0; pready is always high.
//   The front end classifies a header in the cycle it is accepted and places
//   it in a two-entry queue. An item that needs no table lookup passes from
//   the queue into the result register, and such items can follow
//   back to back. A learning lookup scans the peer table one slot per cycle
//   through the table memory's registered read port; the slot that decides
//   it is the first one that matches or is empty, else the last, and the
//   lookup holds the table engine until its item is in the result register.
//   When rsp_stall is high the result register holds its item, the table
//   engine waits, and req_stall rises once the queue is full. Synchronous
//   reset empties the peer table at once through per-slot valid bits,
//   clears the counter and pointer, and restores protocol_type to 0x88AD.
module ether_rx_classify_peer_learn_unit #(
   parameter int TABLE_ENTRIES = erx_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_iface_up,
   input  logic [erx_pkg::IFACE_W-1:0]      req_iface_id,
   input  logic [erx_pkg::ADDR_W-1:0]       req_dst_mac,
   input  logic [erx_pkg::ADDR_W-1:0]       req_source_addr,
   input  logic [erx_pkg::TYPE_W-1:0]       req_frame_type,
   input  logic [erx_pkg::TYPE_W-1:0]       req_llc_type,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [erx_pkg::STATUS_W-1:0]     rsp_status,
   output logic                             rsp_is_broadcast,
   output logic                             rsp_is_multicast,
   output logic                             rsp_llc_encap,
   output logic [erx_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [erx_pkg::ACTION_W-1:0]     rsp_table_action,
   output logic [erx_pkg::COUNT_W-1:0]      rsp_group_count,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [erx_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [erx_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [erx_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import erx_pkg::*;

   logic [TYPE_W-1:0] proto_ff;
   logic              csr_hit;
   logic              queue_full;
   logic              push;
   job_type           push_job;
   logic              pop;
   job_type           pop_job;
   logic              not_empty;
   result_type        rsp;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[2] == CSR_IDX_PROTOCOL_TYPE);
   assign prdata  = csr_hit ? {{(CSR_DATA_W-TYPE_W){1'b0}}, proto_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         proto_ff <= PROTO_RESET;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         proto_ff <= pwdata[TYPE_W-1:0];
      end
   end

   erx_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_iface_up    (req_iface_up),
      .req_iface_id    (req_iface_id),
      .req_dst_mac     (req_dst_mac),
      .req_source_addr (req_source_addr),
      .req_frame_type  (req_frame_type),
      .req_llc_type    (req_llc_type),
      .protocol_type   (proto_ff),
      .queue_full      (queue_full),
      .push            (push),
      .push_job        (push_job)
   );

   erx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .pop_job   (pop_job),
      .not_empty (not_empty)
   );

   erx_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .pop_job   (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_status       = rsp.status;
   assign rsp_is_broadcast = rsp.is_broadcast;
   assign rsp_is_multicast = rsp.is_multicast;
   assign rsp_llc_encap    = rsp.llc_encap;
   assign rsp_slot         = rsp.slot;
   assign rsp_table_action = rsp.table_action;
   assign rsp_group_count  = rsp.group_count;

endmodule
